### rtl/dc_motor_electromechanical_model_assert.svh
// Assertion macros used by the motor model RTL.
`ifndef DC_MOTOR_ELECTROMECHANICAL_MODEL_ASSERT_SVH
`define DC_MOTOR_ELECTROMECHANICAL_MODEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define DCM_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("dcm: implication failed");

// Next-cycle implication, disabled while reset is active.
`define DCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("dcm: next-cycle implication failed");

`endif

### rtl/dcm_pkg.sv
package dcm_pkg;

	// Stream and configuration widths.
	localparam int IN_W       = 80;
	localparam int OUT_W      = 160;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Default substep cap.
	localparam int MAX_SUBSTEPS_DEF = 1024;

	// Substep length in Q0.48.
	localparam logic signed [32:0] STEP_Q48 = 33'sd28147498;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_EMF      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TORQUE_CONST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRICTION      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IND_STEP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INERTIA_STEP  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd7;

	// Register reset values.
	localparam logic [30:0]        RST_RESISTANCE    = 31'd67108864;
	localparam logic [30:0]        RST_BACK_EMF      = 31'd459694;
	localparam logic [30:0]        RST_TORQUE_CONST  = 31'd459694;
	localparam logic [30:0]        RST_FRICTION      = 31'd59;
	localparam logic [31:0]        RST_IND_STEP      = 32'd156180629;
	localparam logic [31:0]        RST_INERTIA_STEP  = 32'd133037469;
	localparam logic signed [31:0] RST_CURRENT_LIMIT = 32'sd655360;
	localparam logic signed [31:0] RST_SPEED_LIMIT   = 32'sd65536000;

	// Sequencer states: besides idle and done, each issues a multiply, accumulates a product, or both.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_DROP,
		ST_MUL_EMF,
		ST_VDIFF,
		ST_MUL_IND,
		ST_CUR,
		ST_MUL_TRQ,
		ST_TRQ,
		ST_TDIFF,
		ST_MUL_SPD,
		ST_SPD,
		ST_MUL_ANG,
		ST_ANG,
		ST_DONE
	} state_t;

endpackage

### rtl/dc_motor_electromechanical_model.sv
// Channel   Direction  Beat contents (lowest bits first)
// s_*       in         drive_voltage[31:0], load_torque[63:32], substeps[74:64]
// m_*       out        position[63:0], speed[95:64], torque[127:96], current[159:128]
// wr_*      in         register index and data, one write per enabled cycle
//
// With n substeps after clamping, the result beat follows the n substeps of the item,
// run one after another on one signed 33 x 33 multiplier, shared by all seven
// products of a substep; with n zero the item goes straight to the result.
// Input is accepted only while the sequencer is idle; a finished result waits
// in the output register and a new item may be accepted meanwhile.
// Reset clears the motor state and loads the register defaults at once.

`include "dc_motor_electromechanical_model_assert.svh"

module dc_motor_electromechanical_model
	import dcm_pkg::*;
#(
	parameter int MAX_SUBSTEPS = MAX_SUBSTEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // drive_voltage, load_torque, substeps, zero pad
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // position, speed, torque, current
	// Configuration writes.
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam int CNT_W = $clog2(MAX_SUBSTEPS + 1);

	state_t state_q, state_d;

	// Configuration registers.
	logic [30:0]        res_q, bemf_q, tc_q, fric_q;
	logic [31:0]        ind_q, inertia_q;
	logic signed [31:0] cur_limit_q, spd_limit_q;

	// Item and motor state.
	logic signed [31:0] volt_q, load_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [31:0] current_q, speed_q, torque_q;
	logic signed [63:0] angle_q;

	// Intermediate values of a substep.
	logic signed [65:0] p_q;
	logic signed [47:0] acc_q;
	logic signed [31:0] vdiff_q, tdiff_q;

	// Output register.
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	// Shared multiplier operands.
	logic               mul_en;
	logic signed [32:0] mul_a, mul_b;

	logic               accept;
	logic [10:0]        n_in;
	logic               out_free;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign accept   = s_tvalid && s_tready;
	assign n_in     = s_tdata[74:64];
	assign out_free = !m_tvalid_q || m_tready;

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q       <= RST_RESISTANCE;
			bemf_q      <= RST_BACK_EMF;
			tc_q        <= RST_TORQUE_CONST;
			fric_q      <= RST_FRICTION;
			ind_q       <= RST_IND_STEP;
			inertia_q   <= RST_INERTIA_STEP;
			cur_limit_q <= RST_CURRENT_LIMIT;
			spd_limit_q <= RST_SPEED_LIMIT;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RESISTANCE:    res_q       <= wr_data[30:0];
				REG_BACK_EMF:      bemf_q      <= wr_data[30:0];
				REG_TORQUE_CONST:  tc_q        <= wr_data[30:0];
				REG_FRICTION:      fric_q      <= wr_data[30:0];
				REG_IND_STEP:      ind_q       <= wr_data;
				REG_INERTIA_STEP:  inertia_q   <= wr_data;
				REG_CURRENT_LIMIT: cur_limit_q <= signed'(wr_data);
				REG_SPEED_LIMIT:   spd_limit_q <= signed'(wr_data);
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (n_in == 11'd0) ? ST_DONE : ST_MUL_DROP;
				end
			end
			ST_MUL_DROP: state_d = ST_MUL_EMF;
			ST_MUL_EMF:  state_d = ST_VDIFF;
			ST_VDIFF:    state_d = ST_MUL_IND;
			ST_MUL_IND:  state_d = ST_CUR;
			ST_CUR:      state_d = ST_MUL_TRQ;
			ST_MUL_TRQ:  state_d = ST_TRQ;
			ST_TRQ:      state_d = ST_TDIFF;
			ST_TDIFF:    state_d = ST_MUL_SPD;
			ST_MUL_SPD:  state_d = ST_SPD;
			ST_SPD:      state_d = ST_MUL_ANG;
			ST_MUL_ANG:  state_d = ST_ANG;
			ST_ANG: begin
				// The drop product of the next substep is issued here.
				state_d = (cnt_q == CNT_W'(1)) ? ST_DONE : ST_MUL_EMF;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Multiplier operand selection and handshake outputs.
	always_comb begin
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL_DROP, ST_ANG: begin
				mul_en = 1'b1;
				mul_a  = 33'(current_q);
				mul_b  = signed'({2'b00, res_q});
			end
			ST_MUL_EMF: begin
				mul_en = 1'b1;
				mul_a  = signed'({2'b00, bemf_q});
				mul_b  = 33'(speed_q);
			end
			ST_MUL_IND: begin
				mul_en = 1'b1;
				mul_a  = 33'(vdiff_q);
				mul_b  = signed'({1'b0, ind_q});
			end
			ST_MUL_TRQ: begin
				mul_en = 1'b1;
				mul_a  = signed'({2'b00, tc_q});
				mul_b  = 33'(current_q);
			end
			ST_TRQ: begin
				mul_en = 1'b1;
				mul_a  = signed'({2'b00, fric_q});
				mul_b  = 33'(speed_q);
			end
			ST_MUL_SPD: begin
				mul_en = 1'b1;
				mul_a  = 33'(tdiff_q);
				mul_b  = signed'({1'b0, inertia_q});
			end
			ST_MUL_ANG: begin
				mul_en = 1'b1;
				mul_a  = 33'(speed_q);
				mul_b  = STEP_Q48;
			end
			ST_VDIFF, ST_CUR, ST_TDIFF, ST_SPD, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Shared multiplier with its product register.
	always_ff @(posedge clk) begin
		if (mul_en) begin
			p_q <= mul_a * mul_b;
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item capture and substep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (32'(n_in) > 32'(MAX_SUBSTEPS)) begin
				cnt_q <= CNT_W'(MAX_SUBSTEPS);
			end else begin
				cnt_q <= CNT_W'(n_in);
			end
		end else if (state_q == ST_ANG) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			volt_q <= signed'(s_tdata[31:0]);
			load_q <= signed'(s_tdata[63:32]);
		end
	end

	// Accumulate steps of a substep.
	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [63:0] sum;
		logic signed [64:0] ang_sum;
		logic signed [63:0] ang_inc;
		if (!arst_n) begin
			current_q <= '0;
			speed_q   <= '0;
			torque_q  <= '0;
			angle_q   <= '0;
		end else begin
			sum     = '0;
			ang_sum = '0;
			ang_inc = '0;
			unique case (state_q)
				ST_CUR: begin
					sum = 64'(current_q) + 64'(signed'(p_q[65:32]));
					if (sum > 64'(cur_limit_q)) begin
						sum = 64'(cur_limit_q);
					end
					current_q <= sat32(sum);
				end
				ST_TRQ: begin
					torque_q <= sat32(64'(signed'(p_q[65:16])));
				end
				ST_SPD: begin
					sum = 64'(speed_q) + 64'(signed'(p_q[65:40]));
					if (sum > 64'(spd_limit_q)) begin
						sum = 64'(spd_limit_q);
					end
					speed_q <= sat32(sum);
				end
				ST_ANG: begin
					// Saturating 64-bit add: overflow shows as differing top bits.
					ang_inc = 64'(signed'(p_q[65:32]));
					ang_sum = 65'(angle_q) + 65'(ang_inc);
					if (ang_sum[64] != ang_sum[63]) begin
						angle_q <= ang_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
					end else begin
						angle_q <= ang_sum[63:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Voltage and torque differences.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_MUL_EMF: acc_q <= 48'(volt_q) - 48'(signed'(p_q[65:24]));
			ST_VDIFF:   vdiff_q <= sat32(64'(acc_q - 48'(signed'(p_q[65:24]))));
			ST_TDIFF: begin
				tdiff_q <= sat32(64'(torque_q) - 64'(load_q) - 64'(signed'(p_q[65:16])));
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded from the state once the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {current_q, torque_q, speed_q, angle_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Checks on sequencer and datapath.
	`DCM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !s_tready)
	`DCM_ASSERT_IMPLIES(a_result_from_done, clk, arst_n, $rose(m_tvalid_q),
		$past(state_q) == ST_DONE)
	`DCM_ASSERT_IMPLIES(a_current_clamped, clk, arst_n, state_q == ST_MUL_TRQ,
		current_q <= cur_limit_q)
	`DCM_ASSERT_IMPLIES(a_count_live, clk, arst_n,
		(state_q == ST_MUL_EMF) || (state_q == ST_ANG), cnt_q != '0)

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench
	import dcm_pkg::*;
;

	// Result beat, laid out as on m_tdata: position lowest, current highest.
	typedef struct packed {
		logic signed [31:0] current;
		logic signed [31:0] torque;
		logic signed [31:0] speed;
		logic signed [63:0] position;
	} motor_result_t;

	// One row of the directed stimulus; known rows carry a typed-in result.
	typedef struct packed {
		logic [31:0]   volt;
		logic [31:0]   load;
		logic [10:0]   steps;
		logic          known;
		motor_result_t want;
	} stim_row_t;

	localparam int NUM_DIRECTED   = 14;
	localparam int NUM_PHASES     = 8;
	localparam int ITEMS_PER_PHASE = 16;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int SETTLE_CYCLES  = 64;
	localparam int MAX_REPORTS    = 10;

	// Register setting flavours for each phase.
	localparam int CFG_DEFAULT = 0;
	localparam int CFG_HIGH    = 1;
	localparam int CFG_LOW     = 2;
	localparam int CFG_NEAR    = 3;
	localparam int CFG_RANDOM  = 4;

	localparam logic [31:0] V_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] V_MIN = 32'h8000_0000;
	localparam int I32_MAX = 32'h7FFF_FFFF;
	localparam int I32_MIN = 32'h8000_0000;
	localparam longint I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam longint I64_MIN = 64'h8000_0000_0000_0000;
	localparam motor_result_t ZERO_RESULT = '0;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;   // drive_voltage, load_torque, substeps, zero pad
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;   // position, speed, torque, current
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	dc_motor_electromechanical_model dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Motor coefficients as the block holds them.
	bit [30:0] res_q24;
	bit [30:0] bemf_q24;
	bit [30:0] kt_q24;
	bit [30:0] fric_q24;
	bit [31:0] ind_step_q32;
	bit [31:0] inertia_step_q32;
	int        cur_limit_q16;
	int        spd_limit_q16;

	// Motor state carried from item to item.
	int     arm_current_q16;
	int     rotor_speed_q16;
	int     motor_torque_q24;
	longint rotor_angle_q32;

	motor_result_t motor_outputs_due[$];
	int            failures;
	int            idle_cycles;
	bit            send_burst;
	bit            take_burst;
	stim_row_t     directed_rows [NUM_DIRECTED];
	int            phase_plan [NUM_PHASES];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int sat32(longint v);
		if (v > longint'(I32_MAX))
			return I32_MAX;
		if (v < longint'(I32_MIN))
			return I32_MIN;
		return int'(v);
	endfunction

	// Runs the Euler substeps of one item on the motor state and returns the
	// beat the block should produce.
	function automatic motor_result_t integrate_motor(int volt, int load, int unsigned steps);
		longint drop;
		longint emf;
		longint cur;
		longint fr;
		longint spd;
		longint dang;
		longint angle_sum;
		int vdiff;
		int tdiff;
		motor_result_t r;
		if (steps > MAX_SUBSTEPS_DEF)
			steps = MAX_SUBSTEPS_DEF;
		for (int unsigned i = 0; i < steps; i++) begin
			// Armature: voltage less resistive drop and back-EMF.
			drop = (longint'(arm_current_q16) * longint'(res_q24)) >>> 24;
			emf = (longint'(bemf_q24) * longint'(rotor_speed_q16)) >>> 24;
			vdiff = sat32(longint'(volt) - drop - emf);
			cur = longint'(arm_current_q16) +
				((longint'(vdiff) * longint'(ind_step_q32)) >>> 32);
			if (cur > longint'(cur_limit_q16))
				cur = cur_limit_q16;
			arm_current_q16 = sat32(cur);

			// Rotor: motor torque against load and viscous friction.
			motor_torque_q24 = sat32((longint'(kt_q24) * longint'(arm_current_q16)) >>> 16);
			fr = (longint'(fric_q24) * longint'(rotor_speed_q16)) >>> 16;
			tdiff = sat32(longint'(motor_torque_q24) - longint'(load) - fr);
			spd = longint'(rotor_speed_q16) +
				((longint'(tdiff) * longint'(inertia_step_q32)) >>> 40);
			if (spd > longint'(spd_limit_q16))
				spd = spd_limit_q16;
			rotor_speed_q16 = sat32(spd);

			// Angle accumulates with saturation at the 64 bit range.
			dang = (longint'(rotor_speed_q16) * longint'(STEP_Q48)) >>> 32;
			angle_sum = rotor_angle_q32 + dang;
			if (dang > 0 && angle_sum < rotor_angle_q32)
				angle_sum = I64_MAX;
			else if (dang < 0 && angle_sum > rotor_angle_q32)
				angle_sum = I64_MIN;
			rotor_angle_q32 = angle_sum;
		end
		r.position = rotor_angle_q32;
		r.speed = rotor_speed_q16;
		r.torque = motor_torque_q24;
		r.current = arm_current_q16;
		return r;
	endfunction

	function automatic int draw_gap(ref bit burst);
		if ($urandom_range(0, 19) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, 17);
	endfunction

	task automatic flag_mismatch(string field, longint want, longint got);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("mismatch in %s: expected %0d, got %0d", field, want, got);
	endtask

	// One register write per cycle; the predictor follows at once.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
			REG_RESISTANCE:    res_q24 = data[30:0];
			REG_BACK_EMF:      bemf_q24 = data[30:0];
			REG_TORQUE_CONST:  kt_q24 = data[30:0];
			REG_FRICTION:      fric_q24 = data[30:0];
			REG_IND_STEP:      ind_step_q32 = data;
			REG_INERTIA_STEP:  inertia_step_q32 = data;
			REG_CURRENT_LIMIT: cur_limit_q16 = data;
			REG_SPEED_LIMIT:   spd_limit_q16 = data;
			default: ;
		endcase
	endtask

	// Writes every register; only called while nothing is in flight.
	task automatic load_settings(int flavour);
		case (flavour)
			CFG_HIGH: begin
				// Bit 31 set on the narrow registers checks that it is dropped.
				write_reg(REG_RESISTANCE, 32'hFFFF_FFFF);
				write_reg(REG_BACK_EMF, 32'hFFFF_FFFF);
				write_reg(REG_TORQUE_CONST, 32'hFFFF_FFFF);
				write_reg(REG_FRICTION, 32'hFFFF_FFFF);
				write_reg(REG_IND_STEP, 32'hFFFF_FFFF);
				write_reg(REG_INERTIA_STEP, 32'hFFFF_FFFF);
				write_reg(REG_CURRENT_LIMIT, V_MAX);
				write_reg(REG_SPEED_LIMIT, V_MAX);
			end
			CFG_LOW: begin
				// Most negative limits force current and speed down every substep.
				write_reg(REG_RESISTANCE, 32'h0);
				write_reg(REG_BACK_EMF, 32'h0);
				write_reg(REG_TORQUE_CONST, 32'h0);
				write_reg(REG_FRICTION, 32'h0);
				write_reg(REG_IND_STEP, 32'h0);
				write_reg(REG_INERTIA_STEP, 32'h0);
				write_reg(REG_CURRENT_LIMIT, V_MIN);
				write_reg(REG_SPEED_LIMIT, V_MIN);
			end
			CFG_NEAR: begin
				write_reg(REG_RESISTANCE, $urandom_range(0, 32'h1000_0000));
				write_reg(REG_BACK_EMF, $urandom_range(0, 32'h0040_0000));
				write_reg(REG_TORQUE_CONST, $urandom_range(0, 32'h0040_0000));
				write_reg(REG_FRICTION, $urandom_range(0, 4096));
				write_reg(REG_IND_STEP, $urandom);
				write_reg(REG_INERTIA_STEP, $urandom);
				write_reg(REG_CURRENT_LIMIT, $urandom_range(0, 2621440) - 1310720);
				write_reg(REG_SPEED_LIMIT, $urandom_range(0, 262144000) - 131072000);
			end
			CFG_RANDOM: begin
				write_reg(REG_RESISTANCE, $urandom);
				write_reg(REG_BACK_EMF, $urandom);
				write_reg(REG_TORQUE_CONST, $urandom);
				write_reg(REG_FRICTION, $urandom);
				write_reg(REG_IND_STEP, $urandom);
				write_reg(REG_INERTIA_STEP, $urandom);
				write_reg(REG_CURRENT_LIMIT, $urandom);
				write_reg(REG_SPEED_LIMIT, $urandom);
			end
			default: begin
				write_reg(REG_RESISTANCE, {1'b0, RST_RESISTANCE});
				write_reg(REG_BACK_EMF, {1'b0, RST_BACK_EMF});
				write_reg(REG_TORQUE_CONST, {1'b0, RST_TORQUE_CONST});
				write_reg(REG_FRICTION, {1'b0, RST_FRICTION});
				write_reg(REG_IND_STEP, RST_IND_STEP);
				write_reg(REG_INERTIA_STEP, RST_INERTIA_STEP);
				write_reg(REG_CURRENT_LIMIT, RST_CURRENT_LIMIT);
				write_reg(REG_SPEED_LIMIT, RST_SPEED_LIMIT);
			end
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Presents one input beat after a random gap and records its outcome once taken.
	task automatic send_item(logic [31:0] volt, logic [31:0] load, logic [10:0] steps,
		logic known, motor_result_t want);
		int gap;
		motor_result_t predicted;
		gap = draw_gap(send_burst);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, steps, load, volt};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = integrate_motor(volt, load, steps);
		motor_outputs_due.push_back(known ? want : predicted);
	endtask

	// Holds the input side back until every outstanding result has been taken.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (motor_outputs_due.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random back-pressure, each beat checked against the oldest entry.
	initial begin
		int gap;
		motor_result_t got;
		motor_result_t want;
		m_tready = 1'b0;
		forever begin
			gap = draw_gap(take_burst);
			@(negedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			got = m_tdata;
			if (motor_outputs_due.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("result beat with nothing outstanding: %h", m_tdata);
			end else begin
				want = motor_outputs_due.pop_front();
				if (got.position !== want.position)
					flag_mismatch("position", want.position, got.position);
				if (got.speed !== want.speed)
					flag_mismatch("speed", want.speed, got.speed);
				if (got.torque !== want.torque)
					flag_mismatch("torque", want.torque, got.torque);
				if (got.current !== want.current)
					flag_mismatch("current", want.current, got.current);
			end
		end
	end

	// Ends a hung run: counts cycles without a beat on either stream.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [31:0] volt;
		logic [31:0] load;
		logic [10:0] steps;
		send_burst = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		arst_n = 1'b0;

		// Predictor starts from the reset values.
		res_q24 = RST_RESISTANCE;
		bemf_q24 = RST_BACK_EMF;
		kt_q24 = RST_TORQUE_CONST;
		fric_q24 = RST_FRICTION;
		ind_step_q32 = RST_IND_STEP;
		inertia_step_q32 = RST_INERTIA_STEP;
		cur_limit_q16 = RST_CURRENT_LIMIT;
		spd_limit_q16 = RST_SPEED_LIMIT;
		arm_current_q16 = 0;
		rotor_speed_q16 = 0;
		motor_torque_q24 = 0;
		rotor_angle_q32 = 0;

		// The two known rows: zero substeps and an idle motor at rest give all-zero beats.
		directed_rows = '{
			'{32'h0, 32'h0, 11'd0, 1'b1, ZERO_RESULT},
			'{32'h0, 32'h0, 11'd3, 1'b1, ZERO_RESULT},
			'{V_MAX, 32'h0, 11'd1, 1'b0, ZERO_RESULT},
			'{V_MAX, 32'h0, 11'd40, 1'b0, ZERO_RESULT},
			'{32'h0, 32'h0, 11'd0, 1'b0, ZERO_RESULT},
			'{V_MIN, 32'h0, 11'd40, 1'b0, ZERO_RESULT},
			'{32'h0, V_MAX, 11'd12, 1'b0, ZERO_RESULT},
			'{32'h0, V_MIN, 11'd12, 1'b0, ZERO_RESULT},
			'{V_MIN, V_MIN, 11'd2047, 1'b0, ZERO_RESULT},
			'{V_MAX, V_MAX, 11'd1024, 1'b0, ZERO_RESULT},
			'{32'h0001_0000, 32'hFFFF_FFFF, 11'd1025, 1'b0, ZERO_RESULT},
			'{32'hFFFF_FFFF, 32'h0000_0001, 11'd1, 1'b0, ZERO_RESULT},
			'{32'h5555_5555, 32'hAAAA_AAAA, 11'h555, 1'b0, ZERO_RESULT},
			'{32'hAAAA_AAAA, 32'h5555_5555, 11'h2AA, 1'b0, ZERO_RESULT}
		};
		phase_plan = '{CFG_HIGH, CFG_LOW, CFG_NEAR, CFG_RANDOM,
			CFG_NEAR, CFG_DEFAULT, CFG_RANDOM, CFG_NEAR};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed beats under the reset settings.
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_item(directed_rows[i].volt, directed_rows[i].load, directed_rows[i].steps,
				directed_rows[i].known, directed_rows[i].want);
		wait_drained();

		// Random beats, with the registers rewritten between phases.
		for (int p = 0; p < NUM_PHASES; p++) begin
			load_settings(phase_plan[p]);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if ($urandom_range(0, 11) == 0)
					wait_drained();
				volt = ($urandom_range(0, 3) == 0) ? $urandom
					: $urandom_range(0, 3145728) - 1572864;
				load = ($urandom_range(0, 3) == 0) ? $urandom
					: $urandom_range(0, 2097152) - 1048576;
				// Mostly short runs; a few reach or pass the substep cap.
				case ($urandom_range(0, 19))
					0:       steps = $urandom_range(0, 2047);
					1, 2, 3: steps = $urandom_range(17, 128);
					default: steps = $urandom_range(0, 16);
				endcase
				send_item(volt, load, steps, 1'b0, ZERO_RESULT);
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### dc_motor_electromechanical_model.f
+incdir+rtl
rtl/dcm_pkg.sv
rtl/dc_motor_electromechanical_model.sv
verif/testbench.sv
